// ===== hw/rtl/ca2_pkg.sv =====
package ca2_pkg;

   localparam int ANGLE_W  = 17;
   localparam int STEP_MAX = 16;

   localparam logic signed [ANGLE_W-1:0] TURN_HALF    = 17'sd32768;
   localparam logic signed [ANGLE_W-1:0] TURN_QUARTER = 17'sd16384;

   localparam logic [13:0] ATAN_STEP [STEP_MAX] = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
      14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
   };

   typedef struct packed {
      logic valid;
      logic x_neg;
      logic y_neg;
      logic origin;
      logic x_zero;
      logic y_zero;
   } info_type;

endpackage

// ===== hw/rtl/ca2_cell.sv =====
module ca2_cell #(
   parameter int DATA_W = 27,
   parameter int STEP   = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ca2_pkg::info_type                     src_info,
   input  logic signed [DATA_W-1:0]              src_x,
   input  logic signed [DATA_W-1:0]              src_y,
   input  logic signed [ca2_pkg::ANGLE_W-1:0]    src_z,
   output ca2_pkg::info_type                     dst_info,
   output logic signed [DATA_W-1:0]              dst_x,
   output logic signed [DATA_W-1:0]              dst_y,
   output logic signed [ca2_pkg::ANGLE_W-1:0]    dst_z
);
   import ca2_pkg::*;

   localparam logic signed [ANGLE_W-1:0] STEP_ANGLE =
      {{(ANGLE_W-14){1'b0}}, ATAN_STEP[STEP]};

   info_type                    info_ff;
   logic signed [DATA_W-1:0]    x_ff, x_in;
   logic signed [DATA_W-1:0]    y_ff, y_in;
   logic signed [ANGLE_W-1:0]   z_ff, z_in;
   logic signed [DATA_W-1:0]    dx;
   logic signed [DATA_W-1:0]    dy;
   logic                        y_pos;

   // A rotation toward the X axis: the sign of Y picks the direction.
   always_comb begin
      dx    = src_y >>> STEP;
      dy    = src_x >>> STEP;
      y_pos = !src_y[DATA_W-1] && (src_y != '0);
      if (y_pos) begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + STEP_ANGLE;
      end else begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff.valid <= 1'b0;
      end else begin
         info_ff.valid <= src_info.valid;
      end
      info_ff.x_neg  <= src_info.x_neg;
      info_ff.y_neg  <= src_info.y_neg;
      info_ff.origin <= src_info.origin;
      info_ff.x_zero <= src_info.x_zero;
      info_ff.y_zero <= src_info.y_zero;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign dst_info = info_ff;
   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;

endmodule

// ===== hw/rtl/cordic_atan2_q15.sv =====
// Angle of a signed 16-bit vector by vectoring CORDIC, 65536 counts per turn, so
// that pi comes out as -32768 and the origin gives 0. A request is taken in every
// clock cycle that start is high; busy is always low. The angle appears on
// rsp_angle with rsp_valid high for one cycle. An input register folds the vector
// into the first quadrant, one registered cell of the CORDIC row per iteration
// follows, and an output register restores the quadrant. The receiver cannot
// stall the block, so each result must be taken when it appears.
module cordic_atan2_q15 #(
   parameter int ITERATIONS     = 16,
   parameter int PRESCALE_SHIFT = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_x,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_angle
);
   import ca2_pkg::*;

   localparam int DATA_W = 16 + PRESCALE_SHIFT + 3;

   info_type                    info_ff, info_in;
   logic signed [DATA_W-1:0]    x0_ff, x0_in;
   logic signed [DATA_W-1:0]    y0_ff, y0_in;
   logic [15:0]                 mag_x;
   logic [15:0]                 mag_y;

   info_type                    chain_info [ITERATIONS+1];
   logic signed [DATA_W-1:0]    chain_x    [ITERATIONS+1];
   logic signed [DATA_W-1:0]    chain_y    [ITERATIONS+1];
   logic signed [ANGLE_W-1:0]   chain_z    [ITERATIONS+1];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]          angle_ff, angle_in;
   logic signed [ANGLE_W-1:0]   quad_angle;
   logic signed [ANGLE_W-1:0]   full_angle;
   info_type                    last_info;

   assign busy = 1'b0;

   always_comb begin
      mag_x = req_vec_x[15] ? 16'(-req_vec_x) : 16'(req_vec_x);
      mag_y = req_vec_y[15] ? 16'(-req_vec_y) : 16'(req_vec_y);
      info_in.valid  = start;
      info_in.x_neg  = req_vec_x[15];
      info_in.y_neg  = req_vec_y[15];
      info_in.origin = (req_vec_x == '0) && (req_vec_y == '0);
      info_in.x_zero = (mag_x == '0);
      info_in.y_zero = (mag_y == '0);
      x0_in = $signed({{(DATA_W-16){1'b0}}, mag_x} << PRESCALE_SHIFT);
      y0_in = $signed({{(DATA_W-16){1'b0}}, mag_y} << PRESCALE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff.valid <= 1'b0;
      end else begin
         info_ff.valid <= info_in.valid;
      end
      info_ff.x_neg  <= info_in.x_neg;
      info_ff.y_neg  <= info_in.y_neg;
      info_ff.origin <= info_in.origin;
      info_ff.x_zero <= info_in.x_zero;
      info_ff.y_zero <= info_in.y_zero;
      x0_ff <= x0_in;
      y0_ff <= y0_in;
   end

   assign chain_info[0] = info_ff;
   assign chain_x[0]    = x0_ff;
   assign chain_y[0]    = y0_ff;
   assign chain_z[0]    = '0;

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      ca2_cell #(
         .DATA_W (DATA_W),
         .STEP   (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .src_info (chain_info[k]),
         .src_x    (chain_x[k]),
         .src_y    (chain_y[k]),
         .src_z    (chain_z[k]),
         .dst_info (chain_info[k+1]),
         .dst_x    (chain_x[k+1]),
         .dst_y    (chain_y[k+1]),
         .dst_z    (chain_z[k+1])
      );
   end

   // Axis cases override the iterated angle, then the input signs restore the quadrant.
   always_comb begin
      last_info = chain_info[ITERATIONS];
      if (last_info.x_zero) begin
         quad_angle = TURN_QUARTER;
      end else if (last_info.y_zero) begin
         quad_angle = '0;
      end else begin
         quad_angle = chain_z[ITERATIONS];
      end
      if (!last_info.x_neg) begin
         full_angle = last_info.y_neg ? -quad_angle : quad_angle;
      end else begin
         full_angle = last_info.y_neg ? (quad_angle - TURN_HALF) : (TURN_HALF - quad_angle);
      end
      angle_in     = last_info.origin ? 16'sd0 : full_angle[15:0];
      rsp_valid_in = last_info.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      angle_ff <= angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = angle_ff;

endmodule
